FILE: rtl/core/pid_filtered_derivative_antiwindup_core_defines.svh
// Assertion macros shared by the checker of the PID core.
`ifndef PID_FILTERED_DERIVATIVE_ANTIWINDUP_CORE_DEFINES_SVH
`define PID_FILTERED_DERIVATIVE_ANTIWINDUP_CORE_DEFINES_SVH

// Antecedent holds in a cycle, consequent in the same cycle.
`define PFDAC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent holds in a cycle, consequent in the next one.
`define PFDAC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/pfdac_pkg.sv
// Package of the PID core: widths, register indexes and sequencer states.
`timescale 1ns / 1ps
package pfdac_pkg;
	localparam int FRAC_BITS = 16;
	localparam int DATA_WIDTH = 32;
	localparam int ACC_WIDTH = 48;
	localparam int MA_W = 49;             // magnitude of multiplicand
	localparam int MB_W = 35;             // magnitude of multiplier
	localparam int MP_W = MA_W + MB_W;    // full product
	localparam int NUM_W = 50;            // dividend magnitude
	localparam int DEN_W = 33;
	localparam int CNT_W = 6;

	localparam logic [2:0] REG_TS   = 3'd0;
	localparam logic [2:0] REG_TC   = 3'd1;
	localparam logic [2:0] REG_KP   = 3'd2;
	localparam logic [2:0] REG_KI   = 3'd3;
	localparam logic [2:0] REG_KD   = 3'd4;
	localparam logic [2:0] REG_BHI  = 3'd5;
	localparam logic [2:0] REG_BLO  = 3'd6;
	localparam logic [2:0] REG_LIM  = 3'd7;

	typedef enum logic [3:0] {
		ST_IDLE, ST_INT_CHK, ST_INT_MUL, ST_DEN_CHK, ST_C1_DIV, ST_C2_DIV,
		ST_D1_MUL, ST_D2_MUL, ST_P_MUL, ST_I_MUL, ST_DK_MUL, ST_OUT
	} state_t;
endpackage

FILE: rtl/core/pid_filtered_derivative_antiwindup_core.sv
// Top level of the PID core with filtered derivative and band anti-windup.
`timescale 1ns / 1ps
// One item (measured, target, restart) gives one drive value and a clamp flag.
// All products and divisions run on one shared shift-add multiplier and one
// restoring divider under a sequencer, one bit per cycle: six products and two
// filter coefficient divisions per item. The two divisions and the two filter
// products are skipped when the filter denominator is zero, and the integrator
// product when the error lies outside the integrator band. The input is ready
// only while the sequencer is idle; a finished result waits in the output
// register, the next item is accepted and computed meanwhile, and it waits in
// the output state only while that register is still full and not taken.
module pid_filtered_derivative_antiwindup_core import pfdac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // measured [31:0], target [63:32]
	input  logic        s_tuser,   // restart
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // drive [31:0]
	output logic        m_tuser,   // clamped
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	state_t state_q, state_d;

	logic [30:0] ts_q, tc_q, lim_q;
	logic signed [31:0] kp_q, ki_q, kd_q, bhi_q, blo_q;

	logic signed [ACC_WIDTH-1:0] integ_q;
	logic signed [DATA_WIDTH-1:0] deriv_q, last_q, err_q;
	logic signed [MB_W-1:0] c1_q, c2_q;
	logic signed [63:0] dterm_q, sum_q;
	logic [CNT_W-1:0] cnt_q;

	logic [MP_W-1:0] ma_q, acc_q;
	logic [MB_W-1:0] mb_q;
	logic neg_q, s17_q;

	logic [NUM_W-1:0] dq_q;
	logic [DEN_W:0] rem_q;
	logic dneg_q;

	logic m_tvalid_q, clamp_q;
	logic [DATA_WIDTH-1:0] drive_q;

	// Error at acceptance, saturated to the data width.
	logic signed [DATA_WIDTH:0] diff_in;
	logic signed [DATA_WIDTH-1:0] err_in;
	assign diff_in = {s_tdata[63], s_tdata[63:32]} - {s_tdata[31], s_tdata[31:0]};
	always_comb begin
		if (diff_in[DATA_WIDTH] != diff_in[DATA_WIDTH-1])
			err_in = diff_in[DATA_WIDTH] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
			                             : {1'b0, {(DATA_WIDTH-1){1'b1}}};
		else
			err_in = diff_in[DATA_WIDTH-1:0];
	end

	logic in_acc;
	assign in_acc = s_tvalid && s_tready;

	// Band test on the error magnitude.
	logic signed [DATA_WIDTH+1:0] mag;
	logic in_band;
	assign mag = err_q[DATA_WIDTH-1] ? -{{2{err_q[DATA_WIDTH-1]}}, err_q}
	                                 : {{2{err_q[DATA_WIDTH-1]}}, err_q};
	assign in_band = (mag < $signed({{2{bhi_q[31]}}, bhi_q}))
	              && (mag > $signed({{2{blo_q[31]}}, blo_q}));

	logic [DEN_W-1:0] den;
	assign den = {1'b0, tc_q, 1'b0} + {2'b00, ts_q};

	// Operand selection for the shared multiplier.
	logic signed [MA_W-1:0] sa;
	logic signed [MB_W-1:0] sb;
	always_comb begin
		sa = '0;
		sb = '0;
		case (state_q)
			ST_INT_MUL: begin
				sa = MA_W'(err_q) + MA_W'(last_q);
				sb = {4'b0000, ts_q};
			end
			ST_D1_MUL: begin
				sa = MA_W'(deriv_q);
				sb = c1_q;
			end
			ST_D2_MUL: begin
				sa = MA_W'(err_q) - MA_W'(last_q);
				sb = c2_q;
			end
			ST_P_MUL: begin
				sa = MA_W'(err_q);
				sb = MB_W'(kp_q);
			end
			ST_I_MUL: begin
				sa = MA_W'(integ_q);
				sb = MB_W'(ki_q);
			end
			ST_DK_MUL: begin
				sa = MA_W'(deriv_q);
				sb = MB_W'(kd_q);
			end
			default: begin
				sa = '0;
				sb = '0;
			end
		endcase
	end

	// Product scaled down, capped at two to the sixtieth, and signed.
	logic [MP_W-1:0] sh;
	logic [60:0] pmag;
	logic signed [63:0] prod;
	assign sh = s17_q ? (acc_q >> (FRAC_BITS + 1)) : (acc_q >> FRAC_BITS);
	assign pmag = (sh > MP_W'(61'h1000_0000_0000_0000)) ? 61'h1000_0000_0000_0000
	                                                     : sh[60:0];
	assign prod = neg_q ? -{3'b000, pmag} : {3'b000, pmag};

	// Divider step: shift in the next dividend bit and try the subtraction.
	logic [DEN_W:0] trial;
	logic fits;
	assign trial = {rem_q[DEN_W-1:0], dq_q[NUM_W-1]};
	assign fits = trial >= {1'b0, den};

	logic signed [NUM_W-1:0] c1_num;
	assign c1_num = (NUM_W'({1'b0, tc_q, 1'b0}) - NUM_W'(ts_q)) <<< FRAC_BITS;

	logic mul_done, div_done;
	assign mul_done = cnt_q == CNT_W'(MB_W + 1);
	assign div_done = cnt_q == CNT_W'(NUM_W + 1);

	// Integrator and derivative sums with saturation.
	logic signed [63:0] int_sum, d_sum;
	logic signed [ACC_WIDTH-1:0] int_sat;
	logic signed [DATA_WIDTH-1:0] d_sat;
	assign int_sum = 64'(integ_q) + prod;
	assign d_sum = dterm_q + prod;
	always_comb begin
		if (int_sum > 64'sh0000_7FFF_FFFF_FFFF)
			int_sat = {1'b0, {(ACC_WIDTH-1){1'b1}}};
		else if (int_sum < -64'sh0000_8000_0000_0000)
			int_sat = {1'b1, {(ACC_WIDTH-1){1'b0}}};
		else
			int_sat = int_sum[ACC_WIDTH-1:0];
		if (d_sum > 64'sh0000_0000_7FFF_FFFF)
			d_sat = {1'b0, {(DATA_WIDTH-1){1'b1}}};
		else if (d_sum < -64'sh0000_0000_8000_0000)
			d_sat = {1'b1, {(DATA_WIDTH-1){1'b0}}};
		else
			d_sat = d_sum[DATA_WIDTH-1:0];
	end

	// Final clamp.
	logic signed [63:0] lim_pos, total;
	assign total = sum_q + prod;
	assign lim_pos = {33'd0, lim_q};

	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (in_acc) state_d = ST_INT_CHK;
			ST_INT_CHK: state_d = in_band ? ST_INT_MUL : ST_DEN_CHK;
			ST_INT_MUL: if (mul_done) state_d = ST_DEN_CHK;
			ST_DEN_CHK: state_d = (den == '0) ? ST_P_MUL : ST_C1_DIV;
			ST_C1_DIV:  if (div_done) state_d = ST_C2_DIV;
			ST_C2_DIV:  if (div_done) state_d = ST_D1_MUL;
			ST_D1_MUL:  if (mul_done) state_d = ST_D2_MUL;
			ST_D2_MUL:  if (mul_done) state_d = ST_P_MUL;
			ST_P_MUL:   if (mul_done) state_d = ST_I_MUL;
			ST_I_MUL:   if (mul_done) state_d = ST_DK_MUL;
			ST_DK_MUL:  if (mul_done) state_d = ST_OUT;
			ST_OUT:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = state_q == ST_IDLE;
		m_tvalid = m_tvalid_q;
		m_tdata = drive_q;
		m_tuser = clamp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ts_q <= 31'd655;
			tc_q <= 31'd3277;
			kp_q <= 32'sd65536;
			ki_q <= '0;
			kd_q <= '0;
			bhi_q <= '0;
			blo_q <= '0;
			lim_q <= 31'h7FFF_FFFF;
			integ_q <= '0;
			deriv_q <= '0;
			last_q <= '0;
			cnt_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_TS:  ts_q <= cfg_data[30:0];
					REG_TC:  tc_q <= cfg_data[30:0];
					REG_KP:  kp_q <= cfg_data;
					REG_KI:  ki_q <= cfg_data;
					REG_KD:  kd_q <= cfg_data;
					REG_BHI: bhi_q <= cfg_data;
					REG_BLO: blo_q <= cfg_data;
					REG_LIM: lim_q <= cfg_data[30:0];
					default: ;
				endcase
			end
			if (m_tvalid_q && m_tready && state_q != ST_OUT) m_tvalid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_acc) begin
						err_q <= err_in;
						if (s_tuser) begin
							integ_q <= '0;
							deriv_q <= '0;
							last_q <= '0;
						end
					end
				end
				ST_INT_CHK: begin
					if (!in_band) integ_q <= '0;
				end
				ST_DEN_CHK: begin
					if (den == '0) begin
						deriv_q <= '0;
						last_q <= err_q;
					end
				end
				ST_C1_DIV, ST_C2_DIV: begin
					if (cnt_q == '0) begin
						rem_q <= '0;
						if (state_q == ST_C1_DIV) begin
							dneg_q <= c1_num[NUM_W-1];
							dq_q <= c1_num[NUM_W-1] ? -c1_num : c1_num;
						end else begin
							dneg_q <= 1'b0;
							dq_q <= NUM_W'(2) << (2 * FRAC_BITS);
						end
						cnt_q <= cnt_q + 1'b1;
					end else if (div_done) begin
						cnt_q <= '0;
						if (state_q == ST_C1_DIV)
							c1_q <= dneg_q ? -MB_W'(dq_q) : MB_W'(dq_q);
						else
							c2_q <= MB_W'(dq_q);
					end else begin
						rem_q <= fits ? trial - {1'b0, den} : trial;
						dq_q <= {dq_q[NUM_W-2:0], fits};
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_INT_MUL, ST_D1_MUL, ST_D2_MUL, ST_P_MUL, ST_I_MUL, ST_DK_MUL: begin
					if (cnt_q == '0) begin
						ma_q <= MP_W'(sa[MA_W-1] ? -sa : sa);
						mb_q <= sb[MB_W-1] ? -sb : sb;
						acc_q <= '0;
						neg_q <= sa[MA_W-1] ^ sb[MB_W-1];
						s17_q <= state_q == ST_INT_MUL;
						cnt_q <= cnt_q + 1'b1;
					end else if (mul_done) begin
						cnt_q <= '0;
						case (state_q)
							ST_INT_MUL: integ_q <= int_sat;
							ST_D1_MUL:  dterm_q <= prod;
							ST_D2_MUL: begin
								deriv_q <= d_sat;
								last_q <= err_q;
							end
							ST_P_MUL:   sum_q <= prod;
							ST_I_MUL:   sum_q <= total;
							ST_DK_MUL:  sum_q <= total;
							default: ;
						endcase
					end else begin
						if (mb_q[0]) acc_q <= acc_q + ma_q;
						ma_q <= ma_q << 1;
						mb_q <= mb_q >> 1;
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						// The limit is below two to the thirty-first, so no
						// further saturation is needed after the clamp.
						if (sum_q > lim_pos) begin
							drive_q <= {1'b0, lim_q};
							clamp_q <= 1'b1;
						end else if (sum_q < -lim_pos) begin
							drive_q <= -{1'b0, lim_q};
							clamp_q <= 1'b1;
						end else begin
							drive_q <= sum_q[DATA_WIDTH-1:0];
							clamp_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule

FILE: rtl/core/pfdac_chk.sv
// Port checker of the PID core and its binding to the top level.
`timescale 1ns / 1ps
`include "pid_filtered_derivative_antiwindup_core_defines.svh"
module pfdac_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);
	`PFDAC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped while stalled")
	`PFDAC_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready, "item accepted while busy")
	`PFDAC_ASSERT_NEXT(a_nofast, s_tvalid && s_tready, !$rose(m_tvalid), "result too early")
	`PFDAC_ASSERT_NOW(a_flag, m_tvalid && !m_tuser, !(m_tdata == 32'h8000_0000), "most negative drive without clamp")
endmodule

bind pid_filtered_derivative_antiwindup_core pfdac_chk u_pfdac_chk (.*);
